>>> hw/rtl/vft_pkg.sv
`timescale 1ns / 1ps
package vft_pkg;

	localparam int FRAC = 16;
	localparam int VAL_W = 31;
	localparam int DQ_W = VAL_W + FRAC;
	localparam int CELLS = DQ_W;

	localparam logic [VAL_W-1:0] UNIT = VAL_W'(1) << FRAC;
	localparam logic [VAL_W-1:0] SCALE_MAX = {VAL_W{1'b1}};

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_VP_W = 3'd1;
	localparam logic [2:0] REG_VP_H = 3'd2;
	localparam logic [2:0] REG_ALIGN = 3'd3;
	localparam logic [2:0] REG_SLICE = 3'd4;

	localparam logic [3:0] MODE_NONE = 4'd0;
	localparam logic [3:0] MODE_LAST = 4'd9;

	localparam logic [1:0] AL_MIN = 2'd0;
	localparam logic [1:0] AL_MID = 2'd1;
	localparam logic [1:0] AL_MAX = 2'd2;

	typedef struct packed {
		logic [DQ_W-1:0] dq;
		logic [VAL_W-1:0] rem;
		logic [VAL_W-1:0] den;
	} lane_t;

	typedef struct packed {
		lane_t [1:0] lane;
		logic [31:0] bx;
		logic [31:0] by;
		logic [VAL_W-1:0] bw;
		logic [VAL_W-1:0] bh;
		logic [VAL_W-1:0] sx;
		logic [VAL_W-1:0] sy;
		logic tight;
		logic bad;
	} ctx_t;

	function automatic logic [1:0] align_x(input logic [3:0] m);
		case (m)
			4'd1, 4'd4, 4'd7: align_x = AL_MIN;
			4'd2, 4'd5, 4'd8: align_x = AL_MID;
			4'd3, 4'd6, 4'd9: align_x = AL_MAX;
			default: align_x = AL_MIN;
		endcase
	endfunction

	function automatic logic [1:0] align_y(input logic [3:0] m);
		case (m)
			4'd1, 4'd2, 4'd3: align_y = AL_MIN;
			4'd4, 4'd5, 4'd6: align_y = AL_MID;
			4'd7, 4'd8, 4'd9: align_y = AL_MAX;
			default: align_y = AL_MIN;
		endcase
	endfunction

endpackage

>>> hw/rtl/viewbox_fit_transform_top.sv
`timescale 1ns / 1ps
// channel   | dir | handshake          | payload
// s (box)   | in  | s_tvalid/s_tready  | s_tdata: box_x, box_y, box_width, box_height
// m (fit)   | out | m_tvalid/m_tready  | m_tdata: scale_x, scale_y, shift_x, shift_y,
//           |     |                    |          not_identity, invalid
// cfg       | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// one item per cycle sustained while m_tready stays high
// two chains of 47 divider cells, one quotient bit per cell, plus the mid and output
// registers: the axis ratios, then viewport over chosen scale
// reset clears all valid bits and loads the register reset values
// a stalled output holds; cells behind it keep filling bubbles until full
module viewbox_fit_transform_top
	import vft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [127:0] s_tdata, // box_x, box_y, box_width, box_height, pad
	output logic m_tvalid,
	input  logic m_tready,
	output logic [127:0] m_tdata, // scale_x, scale_y, shift_x, shift_y, not_identity, invalid
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	logic en_q;
	logic [VAL_W-1:0] vw_q;
	logic [VAL_W-1:0] vh_q;
	logic [3:0] mode_q;
	logic slice_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			vw_q <= UNIT;
			vh_q <= UNIT;
			mode_q <= MODE_NONE;
			slice_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE: en_q <= cfg_data[0];
				REG_VP_W: vw_q <= cfg_data[VAL_W-1:0];
				REG_VP_H: vh_q <= cfg_data[VAL_W-1:0];
				REG_ALIGN: mode_q <= cfg_data[3:0];
				REG_SLICE: slice_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ratio chain input
	ctx_t a_in;
	always_comb begin
		a_in = '0;
		a_in.bx = s_tdata[31:0];
		a_in.by = s_tdata[63:32];
		a_in.bw = s_tdata[94:64];
		a_in.bh = s_tdata[125:95];
		a_in.lane[0].dq = {vw_q, {FRAC{1'b0}}};
		a_in.lane[0].den = s_tdata[94:64];
		a_in.lane[1].dq = {vh_q, {FRAC{1'b0}}};
		a_in.lane[1].den = s_tdata[125:95];
	end

	logic a_v, a_r;
	ctx_t a_out;

	vft_div_chain u_ratio (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_data(a_in),
		.out_valid(a_v),
		.out_ready(a_r),
		.out_data(a_out)
	);

	// scale select
	logic ovf0, ovf1;
	logic [VAL_W-1:0] sx_w, sy_w;
	logic tight_w;
	ctx_t mid_w;

	always_comb begin
		ovf0 = |a_out.lane[0].dq[DQ_W-1:VAL_W];
		ovf1 = |a_out.lane[1].dq[DQ_W-1:VAL_W];
		sx_w = ovf0 ? SCALE_MAX : a_out.lane[0].dq[VAL_W-1:0];
		sy_w = ovf1 ? SCALE_MAX : a_out.lane[1].dq[VAL_W-1:0];
		tight_w = slice_q ? (sx_w >= sy_w) : (sx_w <= sy_w);
		mid_w = a_out;
		mid_w.sx = sx_w;
		mid_w.sy = sy_w;
		mid_w.tight = tight_w;
		mid_w.bad = ovf0 | ovf1;
		mid_w.lane[0].dq = {(tight_w ? vh_q : vw_q), {FRAC{1'b0}}};
		mid_w.lane[0].rem = '0;
		mid_w.lane[0].den = tight_w ? sx_w : sy_w;
		mid_w.lane[1] = '0;
	end

	logic mid_v_s1;
	ctx_t mid_s1;
	logic b_r;

	assign a_r = !mid_v_s1 || b_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_v_s1 <= 1'b0;
		end else if (a_r) begin
			mid_v_s1 <= a_v;
		end
	end

	always_ff @(posedge clk) begin
		if (a_r && a_v) begin
			mid_s1 <= mid_w;
		end
	end

	logic b_v, o_r;
	ctx_t b_out;

	vft_div_chain u_left (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(mid_v_s1),
		.in_ready(b_r),
		.in_data(mid_s1),
		.out_valid(b_v),
		.out_ready(o_r),
		.out_data(b_out)
	);

	// transform assembly
	logic ovfb;
	logic [VAL_W-1:0] qb, size_w, s_w;
	logic [1:0] al_w;
	logic aligned, none_m, left_on;
	logic signed [33:0] d_w, dr_w, half_w, add_w, nbx, nby, tx_w, ty_w;
	logic [31:0] tx_s, ty_s;
	logic [VAL_W-1:0] scx, scy;
	logic bad_w, sat_x, sat_y, nid_w;

	always_comb begin
		none_m = mode_q == MODE_NONE;
		aligned = !none_m && (mode_q <= MODE_LAST);
		s_w = b_out.tight ? b_out.sx : b_out.sy;
		ovfb = |b_out.lane[0].dq[DQ_W-1:VAL_W];
		qb = ovfb ? SCALE_MAX : b_out.lane[0].dq[VAL_W-1:0];
		size_w = b_out.tight ? b_out.bh : b_out.bw;
		al_w = b_out.tight ? align_y(mode_q) : align_x(mode_q);
		left_on = aligned && (b_out.sx != b_out.sy);
		d_w = signed'({3'b000, qb}) - signed'({3'b000, size_w});
		dr_w = d_w + signed'({33'd0, d_w[33]});
		half_w = dr_w >>> 1;
		case (al_w)
			AL_MID: add_w = half_w;
			AL_MAX: add_w = d_w;
			default: add_w = '0;
		endcase
		if (!left_on) begin
			add_w = '0;
		end
		nbx = 34'sd0 - signed'({{2{b_out.bx[31]}}, b_out.bx});
		nby = 34'sd0 - signed'({{2{b_out.by[31]}}, b_out.by});
		if (!en_q) begin
			tx_w = signed'({{2{b_out.bx[31]}}, b_out.bx});
			ty_w = signed'({{2{b_out.by[31]}}, b_out.by});
		end else begin
			tx_w = nbx + (b_out.tight ? 34'sd0 : add_w);
			ty_w = nby + (b_out.tight ? add_w : 34'sd0);
		end
		sat_x = !((tx_w[33:31] == 3'b000) || (tx_w[33:31] == 3'b111));
		sat_y = !((ty_w[33:31] == 3'b000) || (ty_w[33:31] == 3'b111));
		tx_s = sat_x ? (tx_w[33] ? 32'h8000_0000 : 32'h7fff_ffff) : tx_w[31:0];
		ty_s = sat_y ? (ty_w[33] ? 32'h8000_0000 : 32'h7fff_ffff) : ty_w[31:0];
		if (en_q && none_m) begin
			scx = b_out.sx;
			scy = b_out.sy;
		end else if (en_q && aligned) begin
			scx = s_w;
			scy = s_w;
		end else begin
			scx = UNIT;
			scy = UNIT;
		end
		bad_w = sat_x | sat_y
			| (en_q && (none_m || aligned) && b_out.bad)
			| (en_q && left_on && ovfb);
		nid_w = (scx != UNIT) || (scy != UNIT) || (tx_s != '0) || (ty_s != '0);
	end

	logic out_v_q;
	logic [127:0] out_q;

	assign o_r = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (o_r) begin
			out_v_q <= b_v;
		end
	end

	always_ff @(posedge clk) begin
		if (o_r && b_v) begin
			out_q <= {bad_w, nid_w, ty_s, tx_s, scy, scx};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

endmodule

>>> hw/rtl/vft_div_cell.sv
`timescale 1ns / 1ps
module vft_div_cell
	import vft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ctx_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ctx_t out_data
);

	logic v_q;
	ctx_t d_q;
	ctx_t nxt;
	logic [VAL_W:0] r2 [2];
	logic ge [2];

	// one quotient bit per lane
	always_comb begin
		nxt = in_data;
		for (int k = 0; k < 2; k++) begin
			r2[k] = {in_data.lane[k].rem, in_data.lane[k].dq[DQ_W-1]};
			ge[k] = r2[k] >= {1'b0, in_data.lane[k].den};
			nxt.lane[k].rem = ge[k] ? VAL_W'(r2[k] - {1'b0, in_data.lane[k].den})
				: r2[k][VAL_W-1:0];
			nxt.lane[k].dq = {in_data.lane[k].dq[DQ_W-2:0], ge[k]};
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data = d_q;

endmodule

>>> hw/rtl/vft_div_chain.sv
`timescale 1ns / 1ps
module vft_div_chain
	import vft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ctx_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ctx_t out_data
);

	logic v [CELLS+1];
	logic r [CELLS+1];
	ctx_t d [CELLS+1];

	assign v[0] = in_valid;
	assign d[0] = in_data;
	assign in_ready = r[0];

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		vft_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(v[i]),
			.in_ready(r[i]),
			.in_data(d[i]),
			.out_valid(v[i+1]),
			.out_ready(r[i+1]),
			.out_data(d[i+1])
		);
	end

	assign out_valid = v[CELLS];
	assign out_data = d[CELLS];
	assign r[CELLS] = out_ready;

endmodule
